@@ rtl/lrs_pkg.sv @@
// Shared types and constants for the line raster stepper.
// No dependencies; imported by every module of the block.
`default_nettype none

package lrs_pkg;

  // coordinate width of endpoints and emitted points
  localparam int COORD_WIDTH = 16;
  localparam int ACC_W       = COORD_WIDTH + 1;
  localparam int COLOR_W     = 32;
  localparam int CLIP_W      = 15;

  // stream packing, rounded up to whole bytes
  localparam int IN_BITS     = 4 * COORD_WIDTH + COLOR_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * COORD_WIDTH + COLOR_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // clip compare width covers both the coordinate and the clip register
  localparam int CMP_W = ((COORD_WIDTH > CLIP_W) ? COORD_WIDTH : CLIP_W) + 1;

  // item kind codes
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // configuration register indexes
  localparam int   CFG_IDX_W   = 1;
  localparam logic CFG_X_LIMIT = 1'b0;
  localparam logic CFG_Y_LIMIT = 1'b1;

  localparam logic [CLIP_W-1:0] X_LIMIT_RESET = 15'd640;
  localparam logic [CLIP_W-1:0] Y_LIMIT_RESET = 15'd480;

  // one input item
  typedef struct packed {
    logic                   func;
    logic [COORD_WIDTH-1:0] x_start;
    logic [COORD_WIDTH-1:0] y_start;
    logic [COORD_WIDTH-1:0] x_end;
    logic [COORD_WIDTH-1:0] y_end;
    logic [COLOR_W-1:0]     line_color;
  } item_t;

  // one result item
  typedef struct packed {
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic [COLOR_W-1:0]     pixel_color;
    logic                   inside_res;
    logic                   last_point;
    logic                   no_line;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/lrs_in_stage.sv @@
// Input register stage of the line raster stepper.
// Depends on lrs_pkg for the item type.
`default_nettype none

module lrs_in_stage
  import lrs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t in_item_i,
  input  wire logic  adv_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // take a new item when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || adv_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  // control flop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload flop
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/lrs_core.sv @@
// Line state and one-step datapath: start setup, error accumulator step, clip test.
// Depends on lrs_pkg for item and result types.
`default_nettype none

module lrs_core
  import lrs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_en_i,
  input  wire item_t             item_i,
  input  wire logic [CLIP_W-1:0] x_limit_i,
  input  wire logic [CLIP_W-1:0] y_limit_i,
  output res_t                   res_o
);

  localparam int CW = COORD_WIDTH;

  logic [CW-1:0]      cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CW-1:0]      major_q, major_d, minor_q, minor_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [CW-1:0]      steps_q, steps_d;
  logic               x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic               x_major_q, x_major_d;
  logic               active_q, active_d;
  logic [COLOR_W-1:0] color_q, color_d;

  logic [CW:0]        sdx, sdy, adx, ady;
  logic [CW-1:0]      dx, dy;
  logic               st_x_major;
  logic [ACC_W-1:0]   acc_sum;
  logic               minor_step;
  logic [CW-1:0]      x_plus, x_minus, y_plus, y_minus;
  logic               x_inside, y_inside;

  // endpoint spans, one bit wider so the difference cannot wrap
  assign sdx = {item_i.x_end[CW-1], item_i.x_end} - {item_i.x_start[CW-1], item_i.x_start};
  assign sdy = {item_i.y_end[CW-1], item_i.y_end} - {item_i.y_start[CW-1], item_i.y_start};
  assign adx = sdx[CW] ? (~sdx + 1'b1) : sdx;
  assign ady = sdy[CW] ? (~sdy + 1'b1) : sdy;
  assign dx  = adx[CW-1:0];
  assign dy  = ady[CW-1:0];
  assign st_x_major = dx > dy;

  // accumulator step and unit moves
  assign acc_sum    = acc_q + {1'b0, minor_q};
  assign minor_step = acc_sum > {1'b0, major_q};
  assign x_plus     = cur_x_q + 1'b1;
  assign x_minus    = cur_x_q - 1'b1;
  assign y_plus     = cur_y_q + 1'b1;
  assign y_minus    = cur_y_q - 1'b1;

  // next line state
  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    major_d   = major_q;
    minor_d   = minor_q;
    acc_d     = acc_q;
    steps_d   = steps_q;
    x_neg_d   = x_neg_q;
    y_neg_d   = y_neg_q;
    x_major_d = x_major_q;
    active_d  = active_q;
    color_d   = color_q;
    if (item_i.func == FUNC_START) begin
      x_neg_d   = sdx[CW];
      y_neg_d   = sdy[CW];
      x_major_d = st_x_major;
      major_d   = st_x_major ? dx : dy;
      minor_d   = st_x_major ? dy : dx;
      acc_d     = '0;
      steps_d   = st_x_major ? dx : dy;
      cur_x_d   = item_i.x_start;
      cur_y_d   = item_i.y_start;
      color_d   = item_i.line_color;
      active_d  = (st_x_major ? dx : dy) != '0;
    end else if (active_q) begin
      acc_d = minor_step ? (acc_sum - {1'b0, major_q}) : acc_sum;
      if (x_major_q || minor_step) begin
        cur_x_d = x_neg_q ? x_minus : x_plus;
      end
      if (!x_major_q || minor_step) begin
        cur_y_d = y_neg_q ? y_minus : y_plus;
      end
      steps_d  = steps_q - 1'b1;
      active_d = steps_q != CW'(1);
    end
  end

  // clip test on the emitted point
  assign x_inside = !cur_x_d[CW-1] && (CMP_W'(cur_x_d) < CMP_W'(x_limit_i));
  assign y_inside = !cur_y_d[CW-1] && (CMP_W'(cur_y_d) < CMP_W'(y_limit_i));

  // result of this step
  always_comb begin
    res_o = '0;
    if (item_i.func == FUNC_ADVANCE && !active_q) begin
      res_o.no_line = 1'b1;
    end else begin
      res_o.pixel_x     = cur_x_d;
      res_o.pixel_y     = cur_y_d;
      res_o.pixel_color = color_d;
      res_o.inside_res  = x_inside && y_inside;
      res_o.last_point  = !active_d;
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      major_q   <= '0;
      minor_q   <= '0;
      acc_q     <= '0;
      steps_q   <= '0;
      x_neg_q   <= 1'b0;
      y_neg_q   <= 1'b0;
      x_major_q <= 1'b0;
      active_q  <= 1'b0;
      color_q   <= '0;
    end else if (step_en_i) begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      major_q   <= major_d;
      minor_q   <= minor_d;
      acc_q     <= acc_d;
      steps_q   <= steps_d;
      x_neg_q   <= x_neg_d;
      y_neg_q   <= y_neg_d;
      x_major_q <= x_major_d;
      active_q  <= active_d;
      color_q   <= color_d;
    end
  end

  // a line is active exactly while steps remain
  a_active_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q == (steps_q != '0))
    else $error("line active flag disagrees with step count");

  // minor span never exceeds major span
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    minor_q <= major_q)
    else $error("minor span exceeds major span");

  // accumulator stays within the major span
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= {1'b0, major_q})
    else $error("error accumulator out of range");

  // an advance on an active x-major line changes the x coordinate
  a_major_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && item_i.func == FUNC_ADVANCE && active_q && x_major_q)
    |=> (cur_x_q != $past(cur_x_q)))
    else $error("major axis did not step");

endmodule

`default_nettype wire

@@ rtl/lrs_out_stage.sv @@
// Result register stage of the line raster stepper.
// Depends on lrs_pkg for the result type.
`default_nettype none

module lrs_out_stage
  import lrs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire res_t res_i,
  input  wire logic out_ready_i,
  output logic      adv_o,
  output logic      out_valid_o,
  output res_t      res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // the register can take a new result when empty or being drained
  assign adv_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // control flop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload flop
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ rtl/line_raster_stepper.sv @@
// Line raster stepper top level: stream ports, clip registers, stage wiring.
// Depends on lrs_pkg, lrs_in_stage, lrs_core and lrs_out_stage.
//
// Usage: a start item (s_axis_tuser = 0) carries two endpoints and a color
// and yields the first point of the line; each advance item (tuser = 1)
// yields the next point. Every accepted item gives exactly one result on
// the master side. m_axis_tlast marks the last point of a line, and
// m_axis_tuser flags an advance that arrived with no active line.
// The clip window width and height are written through cfg_we_i, index
// 0 / 1; the user must write them only while the block is idle (the block
// does not enforce this). An accepted item waits in the input register
// until the result register can take a result; the core then steps the
// line state. Throughput: one item per cycle while the receiver does not
// stall, set by the combinational accumulator add, compare and subtract.
// Reset clears the line state (no active line) and loads the clip size
// 640 x 480. When the receiver stalls the result register holds, the input
// register takes one more item, and then s_axis_tready drops.
`default_nettype none

module line_raster_stepper
  import lrs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata low to high: x_start, y_start, x_end, y_end, line_color
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func
  input  wire logic                   s_axis_tuser,
  // output stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata low to high: pixel_x, pixel_y, pixel_color, inside_res, zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // tlast: last_point
  output logic                        m_axis_tlast,
  // tuser: no_line
  output logic                        m_axis_tuser,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CLIP_W-1:0]      cfg_data_i
);

  localparam int CW = COORD_WIDTH;

  logic [CLIP_W-1:0] x_limit_q, y_limit_q;
  item_t             s_item, stage_item;
  logic              stage_valid;
  logic              adv;
  res_t              core_res, out_res;

  // clip registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= X_LIMIT_RESET;
      y_limit_q <= Y_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_LIMIT: x_limit_q <= cfg_data_i;
        CFG_Y_LIMIT: y_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unpack input item
  assign s_item.func       = s_axis_tuser;
  assign s_item.x_start    = s_axis_tdata[0*CW +: CW];
  assign s_item.y_start    = s_axis_tdata[1*CW +: CW];
  assign s_item.x_end      = s_axis_tdata[2*CW +: CW];
  assign s_item.y_end      = s_axis_tdata[3*CW +: CW];
  assign s_item.line_color = s_axis_tdata[4*CW +: COLOR_W];

  lrs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (s_item),
    .adv_i      (adv),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  lrs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (stage_valid && adv),
    .item_i    (stage_item),
    .x_limit_i (x_limit_q),
    .y_limit_i (y_limit_q),
    .res_o     (core_res)
  );

  lrs_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stage_valid && adv),
    .res_i       (core_res),
    .out_ready_i (m_axis_tready),
    .adv_o       (adv),
    .out_valid_o (m_axis_tvalid),
    .res_o       (out_res)
  );

  // pack result item
  assign m_axis_tdata = OUT_TDATA_W'({out_res.inside_res, out_res.pixel_color,
                                      out_res.pixel_y, out_res.pixel_x});
  assign m_axis_tlast = out_res.last_point;
  assign m_axis_tuser = out_res.no_line;

endmodule

`default_nettype wire
